// ===== rtl/trd_pkg.sv =====
package trd_pkg;

   // Frame kind: index into the table of known ids, or the unknown code.
   typedef logic [3:0] kind_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ID    = 3'd1,
      ST_BAD_LEN   = 3'd2,
      ST_BAD_SUM   = 3'd3,
      ST_BAD_MAGIC = 3'd4
   } status_type;

   localparam kind_type   KIND_INIT    = 4'd8;
   localparam kind_type   KIND_AXIS    = 4'd9;
   localparam kind_type   KIND_UNKNOWN = 4'd11;
   localparam logic [3:0] ID_NIBBLE    = 4'hd;
   localparam logic [7:0] MAX_LEN      = 8'd11;
   localparam logic [7:0] AXIS_MAGIC   = 8'h14;
   localparam int         STORE_DEPTH  = 6;
   localparam int         STORE_AW     = $clog2(STORE_DEPTH);

   // Map an id byte to its kind.
   function automatic kind_type kind_of(input logic [7:0] id);
      kind_type k;
      case (id)
         8'hd1:   k = 4'd0;
         8'hd2:   k = 4'd1;
         8'hd3:   k = 4'd2;
         8'hd4:   k = 4'd3;
         8'hd5:   k = 4'd4;
         8'hd7:   k = 4'd5;
         8'hd8:   k = 4'd6;
         8'hdf:   k = 4'd7;
         8'hd9:   k = KIND_INIT;
         8'hdc:   k = KIND_AXIS;
         8'hda:   k = 4'd10;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // Fixed body length of each known kind.
   function automatic logic [3:0] len_of(input kind_type k);
      logic [3:0] n;
      case (k)
         4'd4:      n = 4'd3;
         4'd5:      n = 4'd11;
         KIND_AXIS: n = 4'd7;
         4'd10:     n = 4'd3;
         default:   n = 4'd1;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/trd_req_if.sv =====
interface trd_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ===== rtl/trd_rsp_if.sv =====
interface trd_rsp_if;
   logic                  valid;
   logic                  ready;
   trd_pkg::kind_type     frame_kind;
   trd_pkg::status_type   status;
   logic                  touch_valid;
   logic [3:0]            slot;
   logic                  touched;
   logic [13:0]           pos_x;
   logic [13:0]           pos_y;
   logic                  send_settings;

   modport source (output valid, output frame_kind, output status, output touch_valid,
                   output slot, output touched, output pos_x, output pos_y,
                   output send_settings, input ready);
   modport sink   (input valid, input frame_kind, input status, input touch_valid,
                   input slot, input touched, input pos_x, input pos_y,
                   input send_settings, output ready);
endinterface

// ===== rtl/touch_report_deframer.sv =====
// Channel  Dir  Word
// req_ch   in   req_type (rearm), rx_byte
// rsp_ch   out  frame_kind, status, touch_valid, slot, touched, pos_x, pos_y, send_settings
//
// One word is accepted per cycle unless a result stalls. A byte is registered, then parsed
// against the frame state when the output register can take a result; a byte that ends or
// rejects a frame writes a result word into it. Reset is synchronous and returns the parser
// to hunting for an id byte. A stalled result holds the output register; the parse stage
// then waits and the input register holds one more word before req_ch.ready drops.
module touch_report_deframer (
   input logic        clock,
   input logic        reset,
   trd_req_if.sink    req_ch,
   trd_rsp_if.source  rsp_ch
);

   typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_BODY} phase_type;

   // Input register.
   logic       in_vld_ff, in_vld_in;
   logic       in_rearm_ff;
   logic [7:0] in_byte_ff;

   // Frame state.
   phase_type         phase_ff, phase_in;
   trd_pkg::kind_type kind_ff, kind_in;
   logic [3:0]        len_ff, len_in;
   logic [3:0]        count_ff, count_in;
   logic [6:0]        sum_ff, sum_in;
   logic              init_ff, init_in;
   logic [7:0]        store_ff [trd_pkg::STORE_DEPTH];
   logic              store_we;

   // Output register.
   logic                out_vld_ff, out_vld_in;
   trd_pkg::kind_type   res_kind_ff, res_kind_in;
   trd_pkg::status_type res_status_ff, res_status_in;
   logic                res_tv_ff, res_tv_in;
   logic [3:0]          res_slot_ff, res_slot_in;
   logic                res_touched_ff, res_touched_in;
   logic [13:0]         res_x_ff, res_x_in;
   logic [13:0]         res_y_ff, res_y_in;
   logic                res_send_ff, res_send_in;

   logic accept;
   logic advance;
   logic emit;

   // Handshake: the parse stage moves whenever the output slot is free or draining.
   assign advance      = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_vld_in    = accept ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in   = (advance && emit) ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_vld_ff);

   // Parse one byte against the current frame state.
   always_comb begin
      phase_in       = phase_ff;
      kind_in        = kind_ff;
      len_in         = len_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      init_in        = init_ff;
      store_we       = 1'b0;
      emit           = 1'b0;
      res_kind_in    = kind_ff;
      res_status_in  = trd_pkg::ST_OK;
      res_tv_in      = 1'b0;
      res_slot_in    = 4'd0;
      res_touched_in = 1'b0;
      res_x_in       = 14'd0;
      res_y_in       = 14'd0;
      res_send_in    = 1'b0;
      if (in_rearm_ff) begin
         init_in = 1'b0;
      end else begin
         case (phase_ff)
            PH_HUNT: begin
               if (in_byte_ff[7:4] != trd_pkg::ID_NIBBLE) begin
                  emit          = 1'b1;
                  res_kind_in   = trd_pkg::KIND_UNKNOWN;
                  res_status_in = trd_pkg::ST_BAD_ID;
               end else begin
                  kind_in  = trd_pkg::kind_of(in_byte_ff);
                  sum_in   = in_byte_ff[6:0];
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (in_byte_ff == 8'd0 || in_byte_ff > trd_pkg::MAX_LEN) begin
                  emit          = 1'b1;
                  res_status_in = trd_pkg::ST_BAD_LEN;
               end else if (kind_ff == trd_pkg::KIND_UNKNOWN) begin
                  emit          = 1'b1;
                  res_status_in = trd_pkg::ST_BAD_ID;
               end else if (in_byte_ff[3:0] != trd_pkg::len_of(kind_ff)) begin
                  emit          = 1'b1;
                  res_status_in = trd_pkg::ST_BAD_LEN;
               end else begin
                  len_in   = in_byte_ff[3:0];
                  count_in = 4'd0;
                  sum_in   = sum_ff + in_byte_ff[6:0];
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               if (count_ff + 4'd1 < len_ff) begin
                  // Body byte ahead of the checksum.
                  store_we = (count_ff < 4'(trd_pkg::STORE_DEPTH));
                  sum_in   = sum_ff + in_byte_ff[6:0];
                  count_in = count_ff + 4'd1;
               end else begin
                  // Checksum byte closes the frame.
                  emit = 1'b1;
                  if (in_byte_ff != {1'b0, sum_ff}) begin
                     res_status_in = trd_pkg::ST_BAD_SUM;
                  end else if (kind_ff == trd_pkg::KIND_AXIS) begin
                     if (store_ff[0] != trd_pkg::AXIS_MAGIC) begin
                        res_status_in = trd_pkg::ST_BAD_MAGIC;
                     end else if (store_ff[1][7]) begin
                        res_tv_in      = 1'b1;
                        res_slot_in    = store_ff[1][5:2];
                        res_touched_in = store_ff[1][0];
                        if (store_ff[1][0]) begin
                           res_x_in = {store_ff[2], 6'd0} | {6'd0, store_ff[3]};
                           res_y_in = {store_ff[4], 6'd0} | {6'd0, store_ff[5]};
                        end
                     end
                  end else if (kind_ff == trd_pkg::KIND_INIT && !init_ff) begin
                     init_in     = 1'b1;
                     res_send_in = 1'b1;
                  end
               end
            end
            default: phase_in = PH_HUNT;
         endcase
         if (emit) begin
            phase_in = PH_HUNT;
         end
      end
   end

   // State, input register and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PH_HUNT;
         kind_ff    <= 4'd0;
         len_ff     <= 4'd0;
         count_ff   <= 4'd0;
         sum_ff     <= 7'd0;
         init_ff    <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (accept) begin
            in_rearm_ff <= req_ch.req_type;
            in_byte_ff  <= req_ch.rx_byte;
         end
         if (advance) begin
            phase_ff <= phase_in;
            kind_ff  <= kind_in;
            len_ff   <= len_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
            init_ff  <= init_in;
         end
         if (advance && emit) begin
            res_kind_ff    <= res_kind_in;
            res_status_ff  <= res_status_in;
            res_tv_ff      <= res_tv_in;
            res_slot_ff    <= res_slot_in;
            res_touched_ff <= res_touched_in;
            res_x_ff       <= res_x_in;
            res_y_ff       <= res_y_in;
            res_send_ff    <= res_send_in;
         end
      end
   end

   // Body byte store.
   always_ff @(posedge clock) begin
      if (advance && store_we) begin
         store_ff[count_ff[trd_pkg::STORE_AW-1:0]] <= in_byte_ff;
      end
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.frame_kind    = res_kind_ff;
   assign rsp_ch.status        = res_status_ff;
   assign rsp_ch.touch_valid   = res_tv_ff;
   assign rsp_ch.slot          = res_slot_ff;
   assign rsp_ch.touched       = res_touched_ff;
   assign rsp_ch.pos_x         = res_x_ff;
   assign rsp_ch.pos_y         = res_y_ff;
   assign rsp_ch.send_settings = res_send_ff;

   // The result register is empty in the cycle after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !out_vld_ff)
      else $error("result valid right after reset");

   // Contact fields only come from a good axis frame.
   a_touch_axis: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && res_tv_ff) |->
         (res_kind_ff == trd_pkg::KIND_AXIS && res_status_ff == trd_pkg::ST_OK))
      else $error("touch fields on a frame that is not a good axis report");

   // Settings request only on a good init-done frame, and it sets the seen flag.
   a_send_init: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && res_send_ff) |->
         (res_kind_ff == trd_pkg::KIND_INIT && res_status_ff == trd_pkg::ST_OK && init_ff))
      else $error("send_settings without a first good init-done frame");

   // Positions are zero unless the contact is down.
   a_pos_touched: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !res_touched_ff) |-> (res_x_ff == 14'd0 && res_y_ff == 14'd0))
      else $error("position reported for a lifted contact");

   // A stalled result blocks the parse stage.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ch.ready) |=> ($stable(phase_ff) && $stable(sum_ff)))
      else $error("frame state moved while the result was stalled");

endmodule

// ===== test/frame_verifier.sv =====
`timescale 1ns / 1ps

// Watches both channels of the deframer, predicts the result word, if any, of each
// accepted input word, and compares each result word with the oldest prediction.
module frame_verifier
   import trd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   trd_req_if   req_ch,
   trd_rsp_if   rsp_ch,
   output int   error_count,
   output int   pending
);

   // Known ids and their fixed body lengths, index 0 at the right.
   localparam logic [10:0][7:0] FRAME_IDS = {
      8'hda, 8'hdc, 8'hd9, 8'hdf, 8'hd8, 8'hd7, 8'hd5, 8'hd4, 8'hd3, 8'hd2, 8'hd1
   };
   localparam logic [10:0][3:0] FRAME_LENS = {
      4'd3, 4'd7, 4'd1, 4'd1, 4'd1, 4'd11, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1
   };

   typedef enum logic [1:0] {
      HUNT_ID,
      WANT_LEN,
      IN_BODY
   } parse_phase_t;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic        touch_valid;
      logic [3:0]  slot;
      logic        touched;
      logic [13:0] pos_x;
      logic [13:0] pos_y;
      logic        send_settings;
   } frame_report_t;

   // Shadow copy of the parser state.
   parse_phase_t  phase;
   logic [7:0]    frame_id;
   logic [3:0]    frame_length;
   logic [3:0]    body_count;
   logic [6:0]    running_sum;
   logic [7:0]    body_store [STORE_DEPTH];
   logic          init_seen;
   frame_report_t expected_reports [$];

   function automatic kind_type lookup_kind(input logic [7:0] id);
      kind_type k;
      k = KIND_UNKNOWN;
      for (int i = 0; i < 11; i++) begin
         if (FRAME_IDS[i] == id) begin
            k = kind_type'(i);
         end
      end
      return k;
   endfunction

   // Advances the shadow parser by one input word and queues the report it produces.
   task automatic predict_report(input logic rearm, input logic [7:0] b);
      frame_report_t r;
      kind_type      k;
      logic          done;
      r    = '0;
      done = 1'b0;
      k    = lookup_kind(frame_id);
      if (rearm) begin
         init_seen = 1'b0;
      end else begin
         case (phase)
            HUNT_ID: begin
               if (b[7:4] != ID_NIBBLE) begin
                  r.kind   = KIND_UNKNOWN;
                  r.status = ST_BAD_ID;
                  done     = 1'b1;
               end else begin
                  frame_id    = b;
                  running_sum = b[6:0];
                  phase       = WANT_LEN;
               end
            end
            WANT_LEN: begin
               r.kind = k;
               done   = 1'b1;
               if (b == 8'd0 || b > MAX_LEN) begin
                  r.status = ST_BAD_LEN;
               end else if (k == KIND_UNKNOWN) begin
                  r.status = ST_BAD_ID;
               end else if (b[3:0] != FRAME_LENS[k]) begin
                  r.status = ST_BAD_LEN;
               end else begin
                  done         = 1'b0;
                  frame_length = b[3:0];
                  body_count   = 4'd0;
                  running_sum  = running_sum + b[6:0];
                  phase        = IN_BODY;
               end
            end
            default: begin
               if (int'(body_count) + 1 < int'(frame_length)) begin
                  if (body_count < STORE_DEPTH) begin
                     body_store[body_count[STORE_AW-1:0]] = b;
                  end
                  running_sum = running_sum + b[6:0];
                  body_count  = body_count + 4'd1;
               end else begin
                  r.kind = k;
                  done   = 1'b1;
                  if (b != {1'b0, running_sum}) begin
                     r.status = ST_BAD_SUM;
                  end else if (k == KIND_AXIS) begin
                     if (body_store[0] != AXIS_MAGIC) begin
                        r.status = ST_BAD_MAGIC;
                     end else begin
                        r.status = ST_OK;
                        // Contact fields only mean something with the valid bit set.
                        if (body_store[1][7]) begin
                           r.touch_valid = 1'b1;
                           r.slot        = body_store[1][5:2];
                           r.touched     = body_store[1][0];
                           if (body_store[1][0]) begin
                              r.pos_x = {body_store[2], 6'b0} | 14'(body_store[3]);
                              r.pos_y = {body_store[4], 6'b0} | 14'(body_store[5]);
                           end
                        end
                     end
                  end else begin
                     r.status = ST_OK;
                     if (k == KIND_INIT && !init_seen) begin
                        init_seen       = 1'b1;
                        r.send_settings = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
      if (done) begin
         phase = HUNT_ID;
         expected_reports.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [13:0] want,
                              input logic [13:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Compare first, then predict: a result word never leaves in the cycle
   // its input word is taken.
   always @(posedge clock) begin
      frame_report_t want;
      if (reset) begin
         phase        = HUNT_ID;
         frame_id     = 8'd0;
         frame_length = 4'd0;
         body_count   = 4'd0;
         running_sum  = 7'd0;
         init_seen    = 1'b0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            body_store[i] = 8'd0;
         end
         expected_reports.delete();
         error_count = 0;
         pending <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got kind %0d status %0d",
                        $time, rsp_ch.frame_kind, rsp_ch.status);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("frame_kind", want.kind, rsp_ch.frame_kind);
               check_field("status", want.status, rsp_ch.status);
               check_field("touch_valid", want.touch_valid, rsp_ch.touch_valid);
               check_field("slot", want.slot, rsp_ch.slot);
               check_field("touched", want.touched, rsp_ch.touched);
               check_field("pos_x", want.pos_x, rsp_ch.pos_x);
               check_field("pos_y", want.pos_y, rsp_ch.pos_y);
               check_field("send_settings", want.send_settings, rsp_ch.send_settings);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_report(req_ch.req_type, req_ch.rx_byte);
         end
         pending <= expected_reports.size();
      end
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Feeds the deframer with byte streams made mostly of well-formed frames and
// leaves the checking to the frame verifier.
module testbench;
   import trd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int WORD_TARGET = 730;

   // Known ids and their fixed body lengths, index 0 at the right.
   localparam logic [10:0][7:0] FRAME_IDS = {
      8'hda, 8'hdc, 8'hd9, 8'hdf, 8'hd8, 8'hd7, 8'hd5, 8'hd4, 8'hd3, 8'hd2, 8'hd1
   };
   localparam logic [10:0][3:0] FRAME_LENS = {
      4'd3, 4'd7, 4'd1, 4'd1, 4'd1, 4'd11, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1
   };

   // Ways a generated frame can be spoiled.
   typedef enum int {
      FLAW_NONE,
      FLAW_SUM,
      FLAW_LEN,
      FLAW_MAGIC,
      FLAW_CUT
   } flaw_type;

   localparam logic REQ_BYTE  = 1'b0;
   localparam logic REQ_REARM = 1'b1;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   int   cycle_count = 0;
   int   words_sent = 0;
   int   sender_idle_pct = 21;
   int   rsp_stall_pct = 61;

   trd_req_if req_ch ();
   trd_rsp_if rsp_ch ();

   touch_report_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   frame_verifier frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .error_count (errors),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver stalls at random with the current percentage.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Sends one word, idling at random cycles ahead of it, and waits for the handshake.
   task automatic put_word(input logic rearm, input logic [7:0] b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= rearm;
      req_ch.rx_byte  <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      // Swap the idling pattern as the run goes on, then stop idling.
      if (words_sent < 270) begin
         sender_idle_pct = 21;
         rsp_stall_pct   = 61;
      end else if (words_sent < 500) begin
         sender_idle_pct = 61;
         rsp_stall_pct   = 21;
      end else begin
         sender_idle_pct = 0;
         rsp_stall_pct   = 0;
      end
   endtask

   // Builds and sends one frame of the given kind, spoiled as asked.
   task automatic send_frame(input int k, input flaw_type flaw);
      logic [7:0] id_byte;
      logic [7:0] len_byte;
      logic [7:0] body [11];
      logic [6:0] sum;
      int         n;
      int         last;
      id_byte = FRAME_IDS[k];
      n       = FRAME_LENS[k];
      for (int i = 0; i < 11; i++) begin
         body[i] = 8'($urandom_range(0, 255));
      end
      if (k == int'(KIND_AXIS)) begin
         body[0]    = AXIS_MAGIC;
         body[1][7] = ($urandom_range(0, 3) != 0);
         if (flaw == FLAW_MAGIC) begin
            body[0] = 8'($urandom_range(0, 255));
            if (body[0] == AXIS_MAGIC) begin
               body[0] = ~AXIS_MAGIC;
            end
         end
      end
      len_byte = 8'(n);
      if (flaw == FLAW_LEN) begin
         case ($urandom_range(0, 2))
            0:       len_byte = 8'd0;
            1:       len_byte = 8'($urandom_range(12, 255));
            default: len_byte = 8'((n % 11) + 1);
         endcase
      end
      // Checksum over id, length and all body bytes before the last.
      sum = id_byte[6:0] + len_byte[6:0];
      for (int i = 0; i < n - 1; i++) begin
         sum = sum + body[i][6:0];
      end
      body[n - 1] = {1'b0, sum};
      if (flaw == FLAW_SUM) begin
         body[n - 1] = {1'($urandom_range(0, 1)), sum + 7'($urandom_range(1, 127))};
      end
      put_word(REQ_BYTE, id_byte);
      put_word(REQ_BYTE, len_byte);
      if (flaw != FLAW_LEN) begin
         last = (flaw == FLAW_CUT) ? $urandom_range(0, n - 1) : n;
         for (int i = 0; i < last; i++) begin
            // A rearm now and then in the middle of a frame.
            if ($urandom_range(0, 49) == 0) begin
               put_word(REQ_REARM, 8'($urandom_range(0, 255)));
            end
            put_word(REQ_BYTE, body[i]);
         end
      end
   endtask

   // Picks a known kind, with extra weight on the axis and init-done reports.
   function automatic int pick_kind();
      int r;
      r = $urandom_range(0, 14);
      if (r > 12) begin
         r = int'(KIND_INIT);
      end else if (r > 10) begin
         r = int'(KIND_AXIS);
      end
      return r;
   endfunction

   initial begin
      int         r;
      logic [3:0] spare;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_BYTE;
      req_ch.rx_byte  <= 8'd0;
      reset           <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: byte extremes, bad-id and bad-length rejections, init-done around a rearm, axis.
      put_word(REQ_BYTE, 8'h00);
      put_word(REQ_BYTE, 8'hff);
      put_word(REQ_BYTE, 8'hd0);
      put_word(REQ_BYTE, 8'h01);
      put_word(REQ_BYTE, 8'hd1);
      put_word(REQ_BYTE, 8'h00);
      put_word(REQ_BYTE, 8'hd6);
      put_word(REQ_BYTE, 8'h0c);
      put_word(REQ_BYTE, 8'hd2);
      put_word(REQ_BYTE, 8'h02);
      send_frame(int'(KIND_INIT), FLAW_NONE);
      put_word(REQ_REARM, 8'h00);
      send_frame(int'(KIND_INIT), FLAW_NONE);
      send_frame(int'(KIND_AXIS), FLAW_NONE);

      // Random part: mostly clean frames, the rest spoiled frames and noise.
      while (words_sent < WORD_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_frame(pick_kind(), FLAW_NONE);
         end else if (r < 76) begin
            send_frame(pick_kind(), FLAW_SUM);
         end else if (r < 80) begin
            send_frame(int'(KIND_AXIS), FLAW_MAGIC);
         end else if (r < 85) begin
            send_frame(pick_kind(), FLAW_LEN);
         end else if (r < 89) begin
            send_frame(pick_kind(), FLAW_CUT);
         end else if (r < 92) begin
            // An id in the right range that no controller uses.
            case ($urandom_range(0, 4))
               0:       spare = 4'h0;
               1:       spare = 4'h6;
               2:       spare = 4'hb;
               3:       spare = 4'hd;
               default: spare = 4'he;
            endcase
            put_word(REQ_BYTE, {ID_NIBBLE, spare});
            put_word(REQ_BYTE, 8'($urandom_range(0, 15)));
         end else if (r < 97) begin
            put_word(REQ_BYTE, 8'($urandom_range(0, 255)));
         end else begin
            put_word(REQ_REARM, 8'($urandom_range(0, 255)));
         end
      end
      req_ch.valid <= 1'b0;

      // Drain the outstanding results, then allow for the pipeline depth.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/trd_pkg.sv
rtl/trd_req_if.sv
rtl/trd_rsp_if.sv
rtl/touch_report_deframer.sv
test/frame_verifier.sv
test/testbench.sv
